// ----- hdl/signed_int_to_fixed_width_decimal_text_core_assert.svh -----
// assertion macros shared by the checker
`ifndef SIGNED_INT_TO_FIXED_WIDTH_DECIMAL_TEXT_CORE_ASSERT_SVH
`define SIGNED_INT_TO_FIXED_WIDTH_DECIMAL_TEXT_CORE_ASSERT_SVH

// same-cycle implication
`define SITD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SITD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/sitd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sitd_pkg;

  localparam int unsigned MAX_WIDTH  = 10;
  localparam int unsigned POS_W      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LAY_W      = 6;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int unsigned DIG_W      = 4;
  localparam int unsigned CFG_W      = 4;

  localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [CFG_W-1:0] FW_RESET = 4'd10;
  localparam logic [CFG_W-1:0] DP_RESET = 4'd0;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_NINE  = 7'h39;
  localparam logic [6:0] CHAR_POINT = 7'h2E;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_SPACE = 7'h20;

  localparam logic REG_FIELD_WIDTH    = 1'b0;
  localparam logic REG_DECIMAL_PLACES = 1'b1;

  typedef struct packed {
    logic                 load;
    logic                 prep;
    logic                 step;
    logic                 emit;
    logic [DIG_IDX_W-1:0] widx;
    logic [POS_W-1:0]     pos;
    logic [POS_W-1:0]     point_pos;
    logic [POS_W-1:0]     span;
    logic                 last;
  } sitd_cmd_t;

  typedef struct packed {
    logic q_zero;
    logic out_free;
  } sitd_sts_t;

endpackage

`default_nettype wire

// ----- hdl/sitd_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sitd_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- hdl/sitd_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sitd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/signed_int_to_fixed_width_decimal_text_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// after the input beat the core steps through PREP, EXTRACT (d = digit count, 1..10),
// SETUP and EMIT (w characters, w = field width, at most 10); a new input waits for IDLE
// the item time is set by the divide-by-ten loop, one digit per cycle through one multiplier,
// and by the one-character output register
// reset: synchronous active-low rst_n, field_width returns to 10, decimal_places to 0

module signed_int_to_fixed_width_decimal_text_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  sitd_in_if.sink                      in_ch,
  sitd_out_if.source                   out_ch,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [sitd_pkg::CFG_W-1:0] fw_r;
  logic [sitd_pkg::CFG_W-1:0] dp_r;
  logic                       wr_en;

  sitd_pkg::sitd_cmd_t cmd;
  sitd_pkg::sitd_sts_t sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= sitd_pkg::FW_RESET;
      dp_r <= sitd_pkg::DP_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        sitd_pkg::REG_FIELD_WIDTH:    fw_r <= pwdata[sitd_pkg::CFG_W-1:0];
        sitd_pkg::REG_DECIMAL_PLACES: dp_r <= pwdata[sitd_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sitd_pkg::REG_FIELD_WIDTH:    prdata = 32'(fw_r);
      sitd_pkg::REG_DECIMAL_PLACES: prdata = 32'(dp_r);
      default:                      prdata = '0;
    endcase
  end

  sitd_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .field_width    (fw_r),
    .decimal_places (dp_r),
    .sts            (sts),
    .cmd            (cmd)
  );

  sitd_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_ch.value),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_character (out_ch.character),
    .out_last      (out_ch.last)
  );

endmodule

`default_nettype wire

// ----- hdl/sitd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sitd_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [sitd_pkg::CFG_W-1:0] field_width,
  input  wire logic [sitd_pkg::CFG_W-1:0] decimal_places,
  input  wire sitd_pkg::sitd_sts_t       sts,
  output sitd_pkg::sitd_cmd_t            cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_EXTRACT,
    ST_SETUP,
    ST_EMIT
  } state_t;

  localparam int unsigned LW = sitd_pkg::LAY_W;
  localparam int unsigned PW = sitd_pkg::POS_W;

  state_t                            state_r, state_nxt;
  logic [sitd_pkg::DIG_IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [PW-1:0]                     pos_r, pos_nxt;
  logic [PW-1:0]                     point_r, point_nxt;
  logic [PW-1:0]                     span_r, span_nxt;

  logic [LW-1:0] w6, dp6, nd6, ndig, dp1, wm1, lim, len, m6;
  logic          dpm;

  // field layout, counted from the right
  always_comb begin
    dp6  = LW'(decimal_places);
    w6   = (LW'(field_width) > LW'(sitd_pkg::MAX_WIDTH)) ? LW'(sitd_pkg::MAX_WIDTH)
                                                         : LW'(field_width);
    nd6  = LW'(cnt_r) + LW'(1);
    ndig = (nd6 < w6) ? nd6 : w6;
    dpm  = (dp6 != '0) && (ndig < w6);
    dp1  = dp6 + LW'(1);
    wm1  = w6 - LW'(1);
    lim  = (dp1 < wm1) ? dp1 : wm1;
    len  = (ndig > lim) ? ndig : lim;
    m6   = (dp6 < len) ? dp6 : len;
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd.load      = in_valid && (state_r == ST_IDLE);
    cmd.prep      = (state_r == ST_PREP);
    cmd.step      = (state_r == ST_EXTRACT);
    cmd.emit      = (state_r == ST_EMIT) && sts.out_free;
    cmd.widx      = cnt_r;
    cmd.pos       = pos_r;
    cmd.point_pos = point_r;
    cmd.span      = span_r;
    cmd.last      = (pos_r == '0);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    point_nxt = point_r;
    span_nxt  = span_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = ST_EXTRACT;
      end
      ST_EXTRACT: begin
        if (sts.q_zero) begin
          state_nxt = ST_SETUP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SETUP: begin
        pos_nxt   = PW'(w6 - LW'(1));
        point_nxt = dpm ? PW'(m6) : '1;
        span_nxt  = dpm ? PW'(len + LW'(1)) : PW'(ndig);
        state_nxt = (w6 == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          if (pos_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pos_r   <= '0;
      point_r <= '1;
      span_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      point_r <= point_nxt;
      span_r  <= span_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sitd_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sitd_dpath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sitd_pkg::sitd_cmd_t cmd,
  output sitd_pkg::sitd_sts_t     sts,
  input  wire logic signed [31:0] in_value,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [6:0]              out_character,
  output logic                    out_last
);

  localparam int unsigned PW = sitd_pkg::POS_W;
  localparam int unsigned LW = sitd_pkg::LAY_W;

  logic                          neg_r;
  logic [31:0]                   prev_r;
  logic [63:0]                   prod_r;
  logic [sitd_pkg::DIG_W-1:0]    dig_r [sitd_pkg::NUM_DIGITS];
  logic                          out_valid_r;
  logic [6:0]                    out_char_r;
  logic                          out_last_r;

  logic [31:0]                   raw, mag, q, mul_in;
  logic [63:0]                   prod_full;
  logic [3:0]                    q10_lo;
  logic [sitd_pkg::DIG_W-1:0]    digit_new, digit_rd;
  logic [PW-1:0]                 rd_idx;
  logic [LW-1:0]                 rd6;
  logic [6:0]                    char_nxt;

  assign raw = in_value;
  assign mag = raw[31] ? (32'd0 - raw) : raw;

  // quotient by ten through the reciprocal
  assign q         = 32'(prod_r[63:sitd_pkg::RECIP_SHIFT]);
  assign q10_lo    = {q[0], 3'b000} + {q[2:0], 1'b0};
  assign digit_new = prev_r[3:0] - q10_lo;
  assign mul_in    = cmd.prep ? prev_r : q;
  assign prod_full = 64'(mul_in) * 64'(sitd_pkg::RECIP);

  assign sts.q_zero   = (q == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  // character at the current position
  always_comb begin
    rd_idx   = (cmd.pos > cmd.point_pos) ? (cmd.pos - 1'b1) : cmd.pos;
    rd6      = LW'(rd_idx);
    digit_rd = '0;
    if (rd6 < LW'(sitd_pkg::NUM_DIGITS)) begin
      digit_rd = dig_r[rd6[sitd_pkg::DIG_IDX_W-1:0]];
    end
    if (cmd.pos < cmd.span) begin
      if (cmd.pos == cmd.point_pos) begin
        char_nxt = sitd_pkg::CHAR_POINT;
      end else begin
        char_nxt = sitd_pkg::CHAR_ZERO | {3'b000, digit_rd};
      end
    end else if ((cmd.pos == cmd.span) && neg_r) begin
      char_nxt = sitd_pkg::CHAR_MINUS;
    end else begin
      char_nxt = sitd_pkg::CHAR_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r  <= raw[31];
      prev_r <= mag;
      for (int i = 0; i < sitd_pkg::NUM_DIGITS; i++) begin
        dig_r[i] <= '0;
      end
    end
    if (cmd.prep) begin
      prod_r <= prod_full;
    end
    if (cmd.step) begin
      prod_r          <= prod_full;
      prev_r          <= q;
      dig_r[cmd.widx] <= digit_new;
    end
    if (cmd.emit) begin
      out_char_r <= char_nxt;
      out_last_r <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// ----- hdl/sitd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "signed_int_to_fixed_width_decimal_text_core_assert.svh"

module sitd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] out_character,
  input wire logic       out_last
);

  logic is_digit;
  logic is_legal;

  assign is_digit = (out_character >= sitd_pkg::CHAR_ZERO) &&
                    (out_character <= sitd_pkg::CHAR_NINE);
  assign is_legal = is_digit || (out_character == sitd_pkg::CHAR_SPACE) ||
                    (out_character == sitd_pkg::CHAR_MINUS) ||
                    (out_character == sitd_pkg::CHAR_POINT);

  // stalled beat holds
  `SITD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                    out_valid && $stable(out_character) && $stable(out_last))

  // only digits, space, sign or point
  `SITD_ASSERT_NOW(a_char_legal, clk, rst_n, out_valid, is_legal)

  // rightmost character is always a digit
  `SITD_ASSERT_NOW(a_last_digit, clk, rst_n, out_valid && out_last, is_digit)

  // one item at a time
  `SITD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind signed_int_to_fixed_width_decimal_text_core sitd_checker u_sitd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_character (out_ch.character),
  .out_last      (out_ch.last)
);

`default_nettype wire

// ----- test/tb_signed_int_to_fixed_width_decimal_text_core.sv -----
`timescale 1ns / 1ps

module tb_signed_int_to_fixed_width_decimal_text_core;

  localparam int FIELD_MAX  = int'(sitd_pkg::MAX_WIDTH);
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE_CYC = 40;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } char_beat_t;

  class text_board;
    char_beat_t want_q[$];
    logic [3:0] width_reg;
    logic [3:0] places_reg;
    int         errors;

    function new();
      width_reg  = sitd_pkg::FW_RESET;
      places_reg = sitd_pkg::DP_RESET;
      errors     = 0;
    endfunction

    function void set_reg(logic sel, logic [3:0] val);
      if (sel == sitd_pkg::REG_FIELD_WIDTH) begin
        width_reg = val;
      end else begin
        places_reg = val;
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // lay out the field right to left, then queue its characters left to right
    function void note_value(logic [31:0] raw);
      logic [6:0] cells [FIELD_MAX];
      logic [31:0] mag;
      logic        neg;
      int          w, dp, pos, rem, cnt, k, save, i;
      char_beat_t  beat;
      neg = raw[31];
      mag = neg ? (32'd0 - raw) : raw;
      w = int'(width_reg);
      if (w > FIELD_MAX) w = FIELD_MAX;
      if (w == 0) return;
      dp  = int'(places_reg);
      pos = w;
      rem = w;
      cnt = 0;
      forever begin
        rem--;
        pos--;
        cells[pos] = sitd_pkg::CHAR_ZERO + 7'(mag % 32'd10);
        mag = mag / 32'd10;
        if (mag == 32'd0) break;
        cnt++;
        if (rem == 0) break;
      end
      if (dp != 0 && rem > 0) begin
        rem--;
        if (rem > 0 && cnt < dp) begin
          for (k = dp - cnt; k > 0; k--) begin
            pos--;
            cells[pos] = sitd_pkg::CHAR_ZERO;
            cnt++;
            rem--;
            if (rem == 0) break;
          end
        end
        pos--;
        save = pos;
        // integer part moves one slot left to make room for the point
        for (i = cnt - dp; i >= 0; i--) begin
          cells[pos] = cells[pos + 1];
          pos++;
        end
        cells[pos] = sitd_pkg::CHAR_POINT;
        pos = save;
      end
      if (neg && rem > 0) begin
        pos--;
        cells[pos] = sitd_pkg::CHAR_MINUS;
        rem--;
      end
      while (rem > 0) begin
        pos--;
        cells[pos] = sitd_pkg::CHAR_SPACE;
        rem--;
      end
      for (i = 0; i < w; i++) begin
        beat.character = cells[i];
        beat.last      = (i == w - 1);
        want_q.push_back(beat);
      end
    endfunction

    function void check_char(logic [6:0] ch, logic lst);
      char_beat_t want;
      if (want_q.size() == 0) begin
        $error("unexpected character beat: character %h last %b", ch, lst);
        errors++;
        return;
      end
      want = want_q.pop_front();
      if (ch !== want.character) begin
        $error("character: expected %h actual %h", want.character, ch);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last: expected %b actual %b", want.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic steady;
  logic long_hold_due;

  text_board board = new();

  sitd_in_if  in_bus ();
  sitd_out_if out_bus ();

  signed_int_to_fixed_width_decimal_text_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  function automatic logic [31:0] pick_value();
    int          r;
    logic [31:0] m;
    r = $urandom_range(9);
    case (r)
      0: begin
        case ($urandom_range(4))
          0:       m = 32'h0000_0000;
          1:       m = 32'h0000_0001;
          2:       m = 32'hFFFF_FFFF;
          3:       m = 32'h7FFF_FFFF;
          default: m = 32'h8000_0000;
        endcase
        return m;
      end
      1, 2, 3: begin
        m = $urandom_range(999);
        return $urandom_range(1) ? (32'd0 - m) : m;
      end
      4, 5: begin
        m = $urandom_range(99999);
        return $urandom_range(1) ? (32'd0 - m) : m;
      end
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic push_value(input logic [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.value = v;
    do @(posedge clk); while (!in_bus.ready);
    board.note_value(v);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [3:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = {28'd0, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(sel, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic settle();
    in_bus.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic set_format(input logic [3:0] fw, input logic [3:0] dp);
    settle();
    write_reg(sitd_pkg::REG_FIELD_WIDTH, fw);
    write_reg(sitd_pkg::REG_DECIMAL_PLACES, dp);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      board.check_char(out_bus.character, out_bus.last);
    end
  end

  // receiver side, the long hold-off is counted here
  initial begin
    int idle_left;
    idle_left     = 0;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        idle_left     = LONG_HOLD;
      end
      if (idle_left > 0) begin
        out_bus.ready = 1'b0;
        idle_left--;
      end else begin
        out_bus.ready = 1'b1;
        if ($urandom_range(3) == 0) idle_left = pick_gap();
      end
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int          ph, n, j;
    logic [3:0]  fw, dp;
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_bus.valid  = 1'b0;
    in_bus.value  = '0;
    steady        = 1'b0;
    long_hold_due = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset format: ten wide, no point
    push_value(32'h0000_0000);
    push_value(32'h0000_0001);
    push_value(32'hFFFF_FFFF);
    push_value(32'h7FFF_FFFF);
    push_value(32'h8000_0000);
    push_value(32'd123456789);
    push_value(32'd0 - 32'd1000000000);

    set_format(4'd10, 4'd2);
    push_value(32'd12345);
    push_value(32'd0 - 32'd5);
    push_value(32'h8000_0000);

    set_format(4'd4, 4'd3);
    push_value(32'd5);
    push_value(32'd0 - 32'd5);
    push_value(32'd98765);

    // fraction room runs short
    set_format(4'd3, 4'd5);
    push_value(32'd7);
    push_value(32'd0 - 32'd42);

    // sign without room
    set_format(4'd2, 4'd0);
    push_value(32'd0 - 32'd5);
    push_value(32'd0 - 32'd12);

    set_format(4'd1, 4'd0);
    push_value(32'd0 - 32'd7);

    // zero width gives no beats
    set_format(4'd0, 4'd3);
    push_value(32'd99);
    push_value(32'h8000_0000);

    // width above the maximum, large place count
    set_format(4'd15, 4'd15);
    push_value(32'd0 - 32'd123);
    push_value(32'h7FFF_FFFF);

    set_format(4'd5, 4'd9);
    push_value(32'd123);
    push_value(32'd0);

    for (ph = 0; ph < 9; ph++) begin
      n = 17;
      case (ph)
        0: begin
          fw = 4'd10;
          dp = 4'd0;
          n  = 25;
        end
        1: begin
          fw = 4'd1;
          dp = 4'd0;
        end
        2: begin
          fw = 4'd10;
          dp = 4'd9;
        end
        3: begin
          fw = 4'd15;
          dp = 4'd15;
        end
        4: begin
          fw = 4'd0;
          dp = 4'($urandom_range(15));
          n  = 5;
        end
        5: begin
          fw = 4'd3;
          dp = 4'd12;
        end
        default: begin
          fw = 4'($urandom_range(10, 1));
          dp = 4'($urandom_range(9));
        end
      endcase
      set_format(fw, dp);
      steady = (ph == 0) || (ph == 7);
      if (ph == 0) long_hold_due = 1'b1;
      for (j = 0; j < n; j++) push_value(pick_value());
      steady = 1'b0;
    end

    settle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
